FILE: src/frustum_sphere_cull_unit_defines.svh
// Assertion macros for the frustum sphere cull unit.
// Used by frustum_sphere_cull_unit.sv; expects clk and rst_n in scope.
`ifndef FRUSTUM_SPHERE_CULL_UNIT_DEFINES_SVH
`define FRUSTUM_SPHERE_CULL_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fsc_pkg.sv
// Shared types and constants of the frustum sphere cull unit.
// No dependencies.
`default_nettype none
package fsc_pkg;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_DERIVE = 2'd1;
  localparam logic [1:0] CMD_TEST   = 2'd2;

  localparam int COEF_W    = 32;
  localparam int ACC_W     = 66;
  localparam int MAT_DEPTH = 16;

  typedef logic [3:0][COEF_W-1:0] plane_t;

  typedef struct packed {
    logic       shift;
    logic       acc_init;
    logic       acc_en;
    logic [1:0] sel;
  } cell_ctl_t;

  typedef enum logic [1:0] {S_IDLE, S_DERIVE, S_TEST} top_state_t;

  typedef enum logic [3:0] {
    D_IDLE, D_RD, D_RAW, D_SQ, D_CHK, D_SQRT, D_DIVINIT, D_DIV, D_DIVEND, D_PUSH
  } drv_state_t;

  function automatic logic [COEF_W-1:0] sat33(input logic signed [COEF_W:0] v);
    logic [COEF_W-1:0] r;
    if (v[COEF_W] != v[COEF_W-1]) begin
      r = v[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/fsc_in_if.sv
// Request channel of the cull unit: valid/ready plus command payload.
// No dependencies.
`default_nettype none
interface fsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         elem_index;
  logic signed [31:0] elem_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        radius;

  modport source (output valid, cmd, elem_index, elem_value, pos_x, pos_y, pos_z, radius,
                  input ready);
  modport sink (input valid, cmd, elem_index, elem_value, pos_x, pos_y, pos_z, radius,
                output ready);
endinterface
`default_nettype wire

FILE: src/fsc_out_if.sv
// Result channel of the cull unit: valid/ready plus visible flag.
// No dependencies.
`default_nettype none
interface fsc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

FILE: src/fsc_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module fsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

FILE: src/fsc_cell.sv
// One plane cell: holds a plane, does its sphere dot product one term a cycle,
// and ANDs its verdict into the chain. Depends on fsc_pkg.
`default_nettype none
module fsc_cell #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fsc_pkg::cell_ctl_t  ctl,
  input  wire logic signed [31:0]  op,
  input  wire logic [30:0]         rad,
  input  wire fsc_pkg::plane_t     plane_in,
  output fsc_pkg::plane_t          plane_out,
  input  wire logic                vis_in,
  output logic                     vis_out
);
  import fsc_pkg::*;

  plane_t                   coef_r;
  logic signed [63:0]       mul_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     vis_r;
  logic signed [33:0]       base;

  // d + r, both scaled by 2^FRAC_BITS below
  assign base = {{2{coef_r[3][31]}}, coef_r[3]} + {3'b000, rad};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      vis_r  <= 1'b0;
    end else begin
      if (ctl.shift) begin
        coef_r <= plane_in;
      end
      vis_r <= vis_in & ~acc_r[ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= $signed(coef_r[ctl.sel]) * op;
    if (ctl.acc_init) begin
      acc_r <= {{(ACC_W-34){base[33]}}, base} <<< FRAC_BITS;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + {{(ACC_W-64){mul_r[63]}}, mul_r};
    end
  end

  assign plane_out = coef_r;
  assign vis_out   = vis_r;
endmodule
`default_nettype wire

FILE: src/fsc_derive.sv
// Plane derivation sequencer: raw sums, squared length, bit-pair square root
// and restoring division, pushing finished planes into the cell chain. Depends on fsc_pkg.
`default_nettype none
module fsc_derive #(
  parameter int PLANE_COUNT = 6,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic [3:0]              rd_addr_a,
  output logic [3:0]              rd_addr_b,
  input  wire logic signed [31:0] rd_data_a,
  input  wire logic signed [31:0] rd_data_b,
  output logic                    push,
  output fsc_pkg::plane_t         plane
);
  import fsc_pkg::*;

  localparam int KW  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int DW  = 32 + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);
  localparam logic [KW-1:0]  K_LAST   = KW'(PLANE_COUNT - 1);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(DW - 1);

  drv_state_t          state_r, state_nxt;
  logic [KW-1:0]       k_r;
  logic [1:0]          c_r;
  plane_t              raw_r, norm_r;
  logic signed [63:0]  sq_r;
  logic [63:0]         lensq_r, x_r, res_r, one_r;
  logic [4:0]          it_r;
  logic [DW-1:0]       dvd_r;
  logic [31:0]         rem_r;
  logic [DCW-1:0]      bit_r;
  logic                neg_r;

  logic [3:0]          kx;
  logic [1:0]          row;
  logic signed [32:0]  sum_v;
  logic signed [31:0]  sq_op;
  logic [63:0]         trial;
  logic [32:0]         shifted;
  logic [31:0]         len;
  logic [31:0]         comp;
  logic [31:0]         mag;
  logic                big;

  assign kx      = 4'(k_r);
  assign row     = kx[2:1];
  assign sum_v   = k_r[0] ? ({rd_data_a[31], rd_data_a} - {rd_data_b[31], rd_data_b})
                          : ({rd_data_a[31], rd_data_a} + {rd_data_b[31], rd_data_b});
  assign sq_op   = raw_r[c_r];
  assign trial   = res_r + one_r;
  assign len     = res_r[31:0];
  assign shifted = {rem_r, dvd_r[DW-1]};
  assign comp    = raw_r[c_r];
  assign mag     = comp[31] ? (~comp + 32'd1) : comp;
  assign big     = |dvd_r[DW-1:31];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE:    if (start) state_nxt = D_RD;
      D_RD:      state_nxt = D_RAW;
      D_RAW:     state_nxt = (c_r == 2'd3) ? D_SQ : D_RD;
      D_SQ:      if (c_r == 2'd3) state_nxt = D_CHK;
      D_CHK:     state_nxt = (lensq_r == 64'd0) ? D_PUSH : D_SQRT;
      D_SQRT:    if (it_r == 5'd31) state_nxt = D_DIVINIT;
      D_DIVINIT: state_nxt = D_DIV;
      D_DIV:     if (bit_r == DIV_LAST) state_nxt = D_DIVEND;
      D_DIVEND:  state_nxt = (c_r == 2'd3) ? D_PUSH : D_DIVINIT;
      D_PUSH:    state_nxt = (k_r == K_LAST) ? D_IDLE : D_RD;
      default:   state_nxt = D_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != D_IDLE);
    push      = (state_r == D_PUSH);
    plane     = norm_r;
    rd_addr_a = {c_r, 2'd3};
    rd_addr_b = {c_r, row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      k_r     <= '0;
      c_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        D_IDLE:    if (start) begin
          k_r <= '0;
          c_r <= 2'd0;
        end
        D_RAW, D_SQ, D_DIVEND: c_r <= c_r + 2'd1;
        D_SQRT:    c_r <= 2'd0;
        D_PUSH:    begin
          k_r <= k_r + KW'(1);
          c_r <= 2'd0;
        end
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      D_RAW: raw_r[c_r] <= sat33(sum_v);
      D_SQ: begin
        sq_r <= sq_op * sq_op;
        if (c_r == 2'd0) begin
          lensq_r <= 64'd0;
        end else begin
          lensq_r <= lensq_r + 64'(sq_r);
        end
      end
      D_CHK: begin
        norm_r <= raw_r;
        x_r    <= lensq_r;
        res_r  <= 64'd0;
        one_r  <= 64'd1 << 62;
        it_r   <= 5'd0;
      end
      D_SQRT: begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        it_r  <= it_r + 5'd1;
      end
      D_DIVINIT: begin
        dvd_r <= {mag, {FRAC_BITS{1'b0}}};
        rem_r <= 32'd0;
        bit_r <= '0;
        neg_r <= comp[31];
      end
      D_DIV: begin
        if (shifted >= {1'b0, len}) begin
          rem_r <= 32'(shifted - {1'b0, len});
          dvd_r <= {dvd_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= shifted[31:0];
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
        end
        bit_r <= bit_r + DCW'(1);
      end
      D_DIVEND: begin
        if (big) begin
          norm_r[c_r] <= neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          norm_r[c_r] <= neg_r ? (~dvd_r[31:0] + 32'd1) : dvd_r[31:0];
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/frustum_sphere_cull_unit.sv
// Frustum sphere cull unit. A load request writes one matrix element. A derive request
// builds PLANE_COUNT normalized planes one after another in a shared square-root and
// divider sequencer with a one-bit-a-cycle divider. A test request runs all plane cells
// in parallel, one product per cell per cycle, then ripples the verdict down the cell
// row. Requests are taken one at a time; the result sits in an output register, so the
// next request is accepted while it waits.
// Depends on fsc_pkg, fsc_in_if, fsc_out_if, fsc_ram, fsc_cell, fsc_derive and the defines header.
`default_nettype none
`include "frustum_sphere_cull_unit_defines.svh"
module frustum_sphere_cull_unit #(
  parameter int PLANE_COUNT = 6,
  parameter int FRAC_BITS   = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  fsc_in_if.sink   in_ch,
  fsc_out_if.source out_ch
);
  import fsc_pkg::*;

  localparam int TEST_LAST = 4 + PLANE_COUNT;
  localparam int CW        = $clog2(TEST_LAST + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(TEST_LAST);

  top_state_t         state_r, state_nxt;
  logic [CW-1:0]      cnt_r;
  logic [MAT_DEPTH-1:0] mvalid_r;
  logic               ok_a_r, ok_b_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [30:0]        rad_r;
  logic               out_valid_r, out_vis_r;

  logic               accept, finish, drv_start, drv_busy, drv_push;
  logic [3:0]         rd_addr_a, rd_addr_b;
  logic [31:0]        ram_a, ram_b;
  logic signed [31:0] mdata_a, mdata_b;
  plane_t             drv_plane;
  cell_ctl_t          ctl;
  logic signed [31:0] op;
  plane_t             plane_link [PLANE_COUNT+1];
  logic [PLANE_COUNT:0] vis_link;

  assign accept    = in_ch.valid && in_ch.ready;
  assign drv_start = accept && (in_ch.cmd == CMD_DERIVE);
  assign finish    = (state_r == S_TEST) && (cnt_r == CNT_LAST) &&
                     (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.cmd == CMD_DERIVE) state_nxt = S_DERIVE;
        else if (accept && in_ch.cmd == CMD_TEST) state_nxt = S_TEST;
      end
      S_DERIVE: if (!drv_busy) state_nxt = S_IDLE;
      S_TEST:   if (finish) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    ctl.shift    = drv_push;
    ctl.acc_init = (state_r == S_TEST) && (cnt_r == CW'(0));
    ctl.acc_en   = (state_r == S_TEST) &&
                   (cnt_r == CW'(1) || cnt_r == CW'(2) || cnt_r == CW'(3));
    ctl.sel      = cnt_r[1:0];
    case (cnt_r[1:0])
      2'd0:    op = px_r;
      2'd1:    op = py_r;
      default: op = pz_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_ch.cmd == CMD_LOAD) begin
        mvalid_r[in_ch.elem_index] <= 1'b1;
      end
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == S_TEST && cnt_r != CNT_LAST) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_a_r <= mvalid_r[rd_addr_a];
    ok_b_r <= mvalid_r[rd_addr_b];
    if (accept && in_ch.cmd == CMD_TEST) begin
      px_r  <= in_ch.pos_x;
      py_r  <= in_ch.pos_y;
      pz_r  <= in_ch.pos_z;
      rad_r <= in_ch.radius;
    end
    if (finish) begin
      out_vis_r <= vis_link[PLANE_COUNT];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.visible = out_vis_r;

  // never-written elements read as zero
  assign mdata_a = ok_a_r ? $signed(ram_a) : 32'sd0;
  assign mdata_b = ok_b_r ? $signed(ram_b) : 32'sd0;

  fsc_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_matrix (
    .clk     (clk),
    .we      (accept && in_ch.cmd == CMD_LOAD),
    .waddr   (in_ch.elem_index),
    .wdata   (in_ch.elem_value),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  fsc_derive #(.PLANE_COUNT(PLANE_COUNT), .FRAC_BITS(FRAC_BITS)) u_derive (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (drv_start),
    .busy      (drv_busy),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (mdata_a),
    .rd_data_b (mdata_b),
    .push      (drv_push),
    .plane     (drv_plane)
  );

  // planes enter at the far end and shift toward cell 0
  assign plane_link[PLANE_COUNT] = drv_plane;
  assign vis_link[0]             = 1'b1;

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
    fsc_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .op        (op),
      .rad       (rad_r),
      .plane_in  (plane_link[k+1]),
      .plane_out (plane_link[k]),
      .vis_in    (vis_link[k]),
      .vis_out   (vis_link[k+1])
    );
  end

  `FSC_ASSERT_NEXT(a_derive_starts, drv_start, drv_busy, "derive request did not start sequencer")
  `FSC_ASSERT_NOW(a_push_in_derive, drv_push, state_r == S_DERIVE, "plane push outside derive")
  `FSC_ASSERT_NOW(a_test_quiet, state_r == S_TEST, !drv_busy, "derive busy during sphere test")
endmodule
`default_nettype wire
